// ----- hw/rtl/haq_pkg.sv -----
// ============================================================================
// haq_pkg
// shared widths, register indexes, reset values and types for the
// hysteresis alarm qualifier
// ============================================================================
package haq_pkg;

    localparam int TEMP_BITS      = 16;
    localparam int STAT_BITS      = 32;
    localparam int CNT_BITS       = 8;
    localparam int OUT_STAT_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = (TEMP_BITS > CNT_BITS) ? TEMP_BITS : CNT_BITS;
    localparam int IN_TDATA_BITS  = ((TEMP_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 + 2 * OUT_STAT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_RISE_THRESHOLD     = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FALL_THRESHOLD     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONFIRM_COUNT      = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OUTPUT_ACTIVE_HIGH = 2'd3;

    // reset values
    localparam logic signed [TEMP_BITS-1:0] RISE_RESET = TEMP_BITS'(5000);
    localparam logic signed [TEMP_BITS-1:0] FALL_RESET = TEMP_BITS'(4500);
    localparam logic [CNT_BITS-1:0]         CONFIRM_RESET = CNT_BITS'(3);

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] rise_threshold;
        logic signed [TEMP_BITS-1:0] fall_threshold;
        logic [CNT_BITS-1:0]         confirm_count;
        logic                        output_active_high;
    } cfg_t;

    typedef struct packed {
        logic                     alarm_out;
        logic                     pin_level;
        logic                     state_changed;
        logic [OUT_STAT_BITS-1:0] sample_total;
        logic [OUT_STAT_BITS-1:0] transition_count;
    } result_t;

    // statistics counter to the fixed 32-bit output field
    function automatic logic [OUT_STAT_BITS-1:0] stat_out(input logic [STAT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_STAT_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/haq_core.sv -----
// ============================================================================
// haq_core
// debounce counters, alarm state and statistics; one sample per advance
// ============================================================================
module haq_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic signed [haq_pkg::TEMP_BITS-1:0]   temperature,
    input  haq_pkg::cfg_t                          cfg,
    output haq_pkg::result_t                       result
);

    logic                              alarm_reg, alarm_next;
    logic [haq_pkg::CNT_BITS-1:0]      above_reg, above_next;
    logic [haq_pkg::CNT_BITS-1:0]      below_reg, below_next;
    logic [haq_pkg::STAT_BITS-1:0]     samples_reg, samples_next;
    logic [haq_pkg::STAT_BITS-1:0]     trans_reg, trans_next;
    logic [haq_pkg::CNT_BITS-1:0]      need;
    logic [haq_pkg::CNT_BITS-1:0]      above_cnt, below_cnt;
    logic                              changed;

    always_comb
    begin
        // a zero confirm count acts as one
        need = (cfg.confirm_count == '0) ? haq_pkg::CNT_BITS'(1) : cfg.confirm_count;

        // rise test wins when thresholds are crossed
        if (temperature >= cfg.rise_threshold)
        begin
            below_cnt = '0;
            above_cnt = (above_reg < need) ? above_reg + 1'b1 : above_reg;
        end
        else if (temperature <= cfg.fall_threshold)
        begin
            above_cnt = '0;
            below_cnt = (below_reg < need) ? below_reg + 1'b1 : below_reg;
        end
        else
        begin
            above_cnt = '0;
            below_cnt = '0;
        end

        changed = (!alarm_reg && (above_cnt >= need)) || (alarm_reg && (below_cnt >= need));

        samples_next = samples_reg + 1'b1;
        alarm_next   = alarm_reg ^ changed;
        trans_next   = changed ? trans_reg + 1'b1 : trans_reg;
        above_next   = changed ? '0 : above_cnt;
        below_next   = changed ? '0 : below_cnt;

        result.alarm_out        = alarm_next;
        result.pin_level        = ~(alarm_next ^ cfg.output_active_high);
        result.state_changed    = changed;
        result.sample_total     = haq_pkg::stat_out(samples_next);
        result.transition_count = haq_pkg::stat_out(trans_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg   <= 1'b0;
            above_reg   <= '0;
            below_reg   <= '0;
            samples_reg <= '0;
            trans_reg   <= '0;
        end
        else if (advance)
        begin
            alarm_reg   <= alarm_next;
            above_reg   <= above_next;
            below_reg   <= below_next;
            samples_reg <= samples_next;
            trans_reg   <= trans_next;
        end
    end

    // at most one debounce counter runs at a time
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !((above_reg != '0) && (below_reg != '0)))
        else $error("above and below counters both nonzero");

    // a transition leaves both counters cleared
    a_clear_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && changed |=> (above_reg == '0) && (below_reg == '0))
        else $error("counters not cleared after transition");

    // a transition flips the alarm and bumps the transition count
    a_flip_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && changed |=> (alarm_reg != $past(alarm_reg))
            && (trans_reg == $past(trans_reg) + 1'b1))
        else $error("transition did not flip alarm or count");

    // without a transition the alarm and transition count hold
    a_hold_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && changed) |=> $stable(alarm_reg) && $stable(trans_reg))
        else $error("alarm state moved without a transition");

endmodule

// ----- hw/rtl/hysteresis_alarm_qualifier.sv -----
// ============================================================================
// hysteresis_alarm_qualifier
// debounced hysteresis temperature alarm, one result word per sample word
// ============================================================================
// usage
//   - slave stream carries one signed temperature sample per word
//     (hundredths of a degree), master stream returns one result word each
//   - config port: write cfg_wdata to register cfg_addr when cfg_we is high;
//     0 rise threshold, 1 fall threshold, 2 confirm count, 3 pin polarity;
//     write only while no word is in flight
//   - each accepted sample goes from the input register to the result register,
//     which holds its result word; throughput one word per cycle while m_tready
//     stays high, set by the single state update between the two
//   - the receiver may stall freely: the result register holds its word and
//     s_tready drops only when both registers are full and m_tready is low
//   - reset clears the alarm, debounce counters, statistics and both pipeline
//     registers; configuration returns to 5000 / 4500 / 3 / active high
// ============================================================================
module hysteresis_alarm_qualifier (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [haq_pkg::IN_TDATA_BITS-1:0]       s_tdata,   // [15:0] temperature
    // master stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [0] alarm state, [1] pin_level, [2] state_changed,
    // [34:3] sample count, [66:35] transition_count, rest zero
    output logic [haq_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
    // config write port
    input  logic                                    cfg_we,
    input  logic [haq_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  logic [haq_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);

    haq_pkg::cfg_t                         cfg_reg;
    logic                                  in_valid_reg;
    logic signed [haq_pkg::TEMP_BITS-1:0]  temp_reg;
    logic                                  out_valid_reg;
    haq_pkg::result_t                      out_reg;
    haq_pkg::result_t                      result;
    logic                                  advance;

    // input word moves into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_threshold     <= haq_pkg::RISE_RESET;
            cfg_reg.fall_threshold     <= haq_pkg::FALL_RESET;
            cfg_reg.confirm_count      <= haq_pkg::CONFIRM_RESET;
            cfg_reg.output_active_high <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                haq_pkg::REG_RISE_THRESHOLD:
                    cfg_reg.rise_threshold <= cfg_wdata[haq_pkg::TEMP_BITS-1:0];
                haq_pkg::REG_FALL_THRESHOLD:
                    cfg_reg.fall_threshold <= cfg_wdata[haq_pkg::TEMP_BITS-1:0];
                haq_pkg::REG_CONFIRM_COUNT:
                    cfg_reg.confirm_count <= cfg_wdata[haq_pkg::CNT_BITS-1:0];
                haq_pkg::REG_OUTPUT_ACTIVE_HIGH:
                    cfg_reg.output_active_high <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    // input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            temp_reg <= s_tdata[haq_pkg::TEMP_BITS-1:0];
    end

    // alarm state and statistics
    haq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .temperature (temp_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

    // result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = haq_pkg::OUT_TDATA_BITS'({out_reg.transition_count,
                                                out_reg.sample_total,
                                                out_reg.state_changed,
                                                out_reg.pin_level,
                                                out_reg.alarm_out});

endmodule

// ----- tb/hysteresis_alarm_qualifier_tb.sv -----
// ============================================================================
// hysteresis_alarm_qualifier_tb
// self-checking bench for the debounced hysteresis temperature alarm: a
// queue-fed driver streams samples, a clocked monitor checks every result
// word field by field against an in-bench model of the alarm, and the
// thresholds, confirm count and pin polarity are rewritten between phases
// ============================================================================
module hysteresis_alarm_qualifier_tb;

    typedef enum logic [1:0] {RUN_ABOVE, RUN_BELOW, RUN_BETWEEN, RUN_NOISE} run_kind_t;

    // dut ports, all inputs known from time zero
    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [haq_pkg::IN_TDATA_BITS-1:0]  s_tdata   = '0;   // [15:0] temperature
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // [0] alarm state, [1] pin_level, [2] state_changed,
    // [34:3] sample count, [66:35] transition_count, rest zero
    logic [haq_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic                               cfg_we    = 1'b0;
    logic [haq_pkg::CFG_ADDR_BITS-1:0]  cfg_addr  = '0;
    logic [haq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    // samples waiting for the driver, result words waiting for the monitor
    logic [haq_pkg::TEMP_BITS-1:0] temp_samples_q [$];
    haq_pkg::result_t              alarm_words_due [$];

    // configuration as the dut holds it, mirrored from the write port
    logic signed [haq_pkg::TEMP_BITS-1:0] rise_thr;
    logic signed [haq_pkg::TEMP_BITS-1:0] fall_thr;
    logic [haq_pkg::CNT_BITS-1:0]         confirm_cnt;
    logic                                 active_high;

    // alarm state as the dut should hold it
    logic                          alarm_on;
    logic [haq_pkg::CNT_BITS-1:0]  above_cnt;
    logic [haq_pkg::CNT_BITS-1:0]  below_cnt;
    logic [haq_pkg::STAT_BITS-1:0] sample_cnt;
    logic [haq_pkg::STAT_BITS-1:0] trans_cnt;

    // stimulus view of the current setting, used to aim the sample runs
    int stim_rise = 5000;
    int stim_fall = 4500;
    int stim_need = 3;

    // idling odds in percent for each side
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_cnt = 0;

    hysteresis_alarm_qualifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // alarm model: one sample in, the result word it should produce out
    // ------------------------------------------------------------------------
    function automatic haq_pkg::result_t qualify_sample(
        input logic signed [haq_pkg::TEMP_BITS-1:0] temp);
        haq_pkg::result_t             word;
        logic [haq_pkg::CNT_BITS-1:0] need;
        logic                         changed;
        // a confirm count of zero behaves like one
        need    = (confirm_cnt == '0) ? haq_pkg::CNT_BITS'(1) : confirm_cnt;
        changed = 1'b0;
        sample_cnt = sample_cnt + 1'b1;
        // rise test first, so crossed thresholds count a sample as above
        if (temp >= rise_thr)
        begin
            below_cnt = '0;
            if (above_cnt < need)
                above_cnt = above_cnt + 1'b1;
        end
        else if (temp <= fall_thr)
        begin
            above_cnt = '0;
            if (below_cnt < need)
                below_cnt = below_cnt + 1'b1;
        end
        else
        begin
            // in the hysteresis band both debounce runs break
            above_cnt = '0;
            below_cnt = '0;
        end
        if ((!alarm_on && above_cnt >= need) || (alarm_on && below_cnt >= need))
        begin
            alarm_on  = ~alarm_on;
            trans_cnt = trans_cnt + 1'b1;
            above_cnt = '0;
            below_cnt = '0;
            changed   = 1'b1;
        end
        word.alarm_out        = alarm_on;
        word.pin_level        = alarm_on ~^ active_high;
        word.state_changed    = changed;
        word.sample_total     = sample_cnt[haq_pkg::OUT_STAT_BITS-1:0];
        word.transition_count = trans_cnt[haq_pkg::OUT_STAT_BITS-1:0];
        return word;
    endfunction

    // config mirror: follows every write the dut takes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_thr    <= haq_pkg::RISE_RESET;
            fall_thr    <= haq_pkg::FALL_RESET;
            confirm_cnt <= haq_pkg::CONFIRM_RESET;
            active_high <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                haq_pkg::REG_RISE_THRESHOLD:
                    rise_thr    <= cfg_wdata[haq_pkg::TEMP_BITS-1:0];
                haq_pkg::REG_FALL_THRESHOLD:
                    fall_thr    <= cfg_wdata[haq_pkg::TEMP_BITS-1:0];
                haq_pkg::REG_CONFIRM_COUNT:
                    confirm_cnt <= cfg_wdata[haq_pkg::CNT_BITS-1:0];
                haq_pkg::REG_OUTPUT_ACTIVE_HIGH:
                    active_high <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // driver: predicts each accepted sample, then offers the next one
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            alarm_on   = 1'b0;
            above_cnt  = '0;
            below_cnt  = '0;
            sample_cnt = '0;
            trans_cnt  = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                alarm_words_due.push_back(
                    qualify_sample(s_tdata[haq_pkg::TEMP_BITS-1:0]));
            // a held word stays put until taken; otherwise roll for a gap
            if (!s_tvalid || s_tready)
            begin
                if (temp_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= temp_samples_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each accepted result word, stalls at random
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_cnt++;
    endtask

    task automatic check_alarm_word(input logic [haq_pkg::OUT_TDATA_BITS-1:0] got);
        haq_pkg::result_t want;
        if (alarm_words_due.size() == 0)
        begin
            report_mismatch($sformatf("result word with nothing due: %h", got));
            return;
        end
        want = alarm_words_due.pop_front();
        if (got[0] !== want.alarm_out)
            report_mismatch($sformatf("sample %0d alarm state got %b want %b",
                                      want.sample_total, got[0], want.alarm_out));
        if (got[1] !== want.pin_level)
            report_mismatch($sformatf("sample %0d pin_level got %b want %b",
                                      want.sample_total, got[1], want.pin_level));
        if (got[2] !== want.state_changed)
            report_mismatch($sformatf("sample %0d state_changed got %b want %b",
                                      want.sample_total, got[2], want.state_changed));
        if (got[34:3] !== want.sample_total)
            report_mismatch($sformatf("sample count got %0d want %0d",
                                      got[34:3], want.sample_total));
        if (got[66:35] !== want.transition_count)
            report_mismatch($sformatf("sample %0d transition_count got %0d want %0d",
                                      want.sample_total, got[66:35],
                                      want.transition_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_alarm_word(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write; cfg_we is left high so back-to-back writes
    // never lower and raise it in the same step
    task automatic write_reg(input logic [haq_pkg::CFG_ADDR_BITS-1:0] idx,
                             input logic [haq_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // full register set, only called with the pipeline drained
    task automatic set_config(input logic [haq_pkg::CFG_DATA_BITS-1:0] rise,
                              input logic [haq_pkg::CFG_DATA_BITS-1:0] fall,
                              input logic [haq_pkg::CFG_DATA_BITS-1:0] confirm,
                              input logic [haq_pkg::CFG_DATA_BITS-1:0] polarity);
        write_reg(haq_pkg::REG_RISE_THRESHOLD, rise);
        write_reg(haq_pkg::REG_FALL_THRESHOLD, fall);
        write_reg(haq_pkg::REG_CONFIRM_COUNT, confirm);
        write_reg(haq_pkg::REG_OUTPUT_ACTIVE_HIGH, polarity);
        cfg_we    <= 1'b0;
        stim_rise = int'($signed(rise[haq_pkg::TEMP_BITS-1:0]));
        stim_fall = int'($signed(fall[haq_pkg::TEMP_BITS-1:0]));
        stim_need = (confirm[haq_pkg::CNT_BITS-1:0] == '0) ? 1 :
                    int'(confirm[haq_pkg::CNT_BITS-1:0]);
    endtask

    // a run of samples aimed at one region of the current setting
    task automatic add_run(input run_kind_t kind, input int len);
        int v;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                RUN_ABOVE:
                    v = stim_rise + int'($urandom_range(32767 - stim_rise));
                RUN_BELOW:
                    v = -32768 + int'($urandom_range(stim_fall + 32768));
                RUN_BETWEEN:
                    if (stim_rise - stim_fall >= 2)
                        v = stim_fall + 1 + int'($urandom_range(stim_rise - stim_fall - 2));
                    else
                        v = int'($urandom_range(65535)) - 32768;
                default:
                    v = int'($urandom_range(65535)) - 32768;
            endcase
            temp_samples_q.push_back(haq_pkg::TEMP_BITS'(v));
        end
    endtask

    // mostly debounce runs around the confirm count, some short or broken
    // runs, some band samples and some plain noise
    task automatic add_random(input int count);
        int        left;
        int        len;
        int        pick;
        run_kind_t kind;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                kind = RUN_ABOVE;
            else if (pick < 80)
                kind = RUN_BELOW;
            else if (pick < 90)
                kind = RUN_BETWEEN;
            else
                kind = RUN_NOISE;
            len = (kind == RUN_NOISE) ? $urandom_range(3, 1) : $urandom_range(stim_need + 2, 1);
            if (len > left)
                len = left;
            add_run(kind, len);
            left -= len;
        end
    endtask

    // hold the sender until every due result word has come back, then let
    // the two pipeline registers settle
    task automatic drain_pipeline();
        while (temp_samples_q.size() != 0 || s_tvalid || alarm_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one setting, random samples in two halves with a full drain between
    task automatic run_phase(input logic [haq_pkg::CFG_DATA_BITS-1:0] rise,
                             input logic [haq_pkg::CFG_DATA_BITS-1:0] fall,
                             input logic [haq_pkg::CFG_DATA_BITS-1:0] confirm,
                             input logic [haq_pkg::CFG_DATA_BITS-1:0] polarity,
                             input int count);
        set_config(rise, fall, confirm, polarity);
        add_random(count / 2);
        drain_pipeline();
        add_random(count - count / 2);
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idles, receiver stalls most of the time
        send_idle_pct  = 9;
        recv_stall_pct = 87;

        // directed, on reset values 5000 / 4500 / 3 / active high
        // rise threshold met exactly three times sets the alarm
        temp_samples_q = '{16'd5000, 16'd5000, 16'd5000};
        // band sample while active, then a broken clear run
        temp_samples_q.push_back(16'd4999);
        temp_samples_q.push_back(16'd4500);
        temp_samples_q.push_back(16'd4500);
        temp_samples_q.push_back(16'd5000);
        // fall threshold met exactly three times clears it
        temp_samples_q.push_back(16'd4500);
        temp_samples_q.push_back(16'd4500);
        temp_samples_q.push_back(16'd4500);
        // field extremes: broken set run, full set run, full clear run
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'd4501);
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'h7fff);
        temp_samples_q.push_back(16'h8000);
        temp_samples_q.push_back(16'h8000);
        temp_samples_q.push_back(16'h8000);
        // below count saturates while already normal
        temp_samples_q.push_back(16'h8000);
        temp_samples_q.push_back(16'h8000);
        temp_samples_q.push_back(16'h0000);
        temp_samples_q.push_back(16'hffff);
        drain_pipeline();

        run_phase(16'd5000, 16'd4500, 16'd3, 16'd1, 140);
        // negative thresholds, single confirming sample, pin active low
        run_phase(-16'sd200, -16'sd800, 16'd1, 16'd0, 140);
        // crossed thresholds: the rise test wins
        run_phase(16'd100, 16'd300, 16'd2, 16'd1, 110);

        // sender mostly idle, receiver rarely stalls
        send_idle_pct  = 87;
        recv_stall_pct = 9;

        // lowest thresholds: every sample counts as above
        run_phase(16'h8000, 16'h8000, 16'd4, 16'd0, 110);
        // highest thresholds and a zero confirm count
        run_phase(16'h7fff, 16'h7fff, 16'd0, 16'd1, 110);
        // equal thresholds at zero
        run_phase(16'd0, 16'd0, 16'd5, 16'd0, 110);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(8)),
                  16'($urandom_range(1)), 110);

        // no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // largest confirm count: long runs set, then clear
        set_config(16'd2000, -16'sd2000, 16'd255, 16'd1);
        add_run(RUN_ABOVE, 257);
        add_run(RUN_BELOW, 257);
        drain_pipeline();

        // unused upper bits of the write data must be ignored
        run_phase(16'd7000, 16'd6000, 16'ha502, 16'hfffe, 120);

        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
